>>> rtl/adsr_pkg.sv
// shared types and constants of the linear adsr envelope level block
// used by every module in rtl/, no dependencies of its own
`timescale 1ns / 1ps

package adsr_pkg;

  localparam int unsigned TimeW  = 24;              // configured durations
  localparam int unsigned DEndW  = TimeW + 1;       // attack + decay
  localparam int unsigned PosW   = 26;              // position and release end
  localparam int unsigned AmpW   = 12;              // amplitude levels
  localparam int unsigned QuoW   = AmpW;            // ramp step never exceeds a level
  localparam int unsigned ProdW  = AmpW + PosW;     // level delta times offset
  localparam int unsigned DsorW  = PosW + QuoW - 1; // span aligned to top quotient bit
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = TimeW;
  localparam int unsigned DivSteps = QuoW;

  localparam logic [AmpW-1:0] AMP_MAX = 12'd4095;

  typedef enum logic [IdxW-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3
  } reg_idx_e;

  // ramp job after segment selection; a clamped level has diff zero
  typedef struct packed {
    logic [AmpW-1:0] lv0;
    logic            down;
    logic [AmpW-1:0] diff;
    logic [PosW-1:0] off;
    logic [PosW-1:0] span;
  } seg_t;

  // restoring divider state
  typedef struct packed {
    logic [AmpW-1:0]  lv0;
    logic             down;
    logic [ProdW-1:0] rem;
    logic [DsorW-1:0] dsor;
    logic [QuoW-1:0]  quo;
  } div_t;

endpackage

>>> rtl/adsr_seg.sv
// segment select stage: picks the ramp, clamps, forms offset and span
// depends on adsr_pkg
`timescale 1ns / 1ps

module adsr_seg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       opcode_i,
  input  logic [adsr_pkg::PosW-1:0]  position_i,
  input  logic [adsr_pkg::TimeW-1:0] attack_end_i,
  input  logic [adsr_pkg::DEndW-1:0] decay_end_i,
  input  logic [adsr_pkg::PosW-1:0]  release_end_i,
  input  logic [adsr_pkg::AmpW-1:0]  sustain_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output adsr_pkg::seg_t             seg_o
);

  logic [adsr_pkg::PosW-1:0] a_end, d_end, t0, t1;
  logic [adsr_pkg::AmpW-1:0] lv0, lv1;
  logic                      hold;
  logic                      valid_q;
  adsr_pkg::seg_t            seg_d, seg_q;

  assign a_end = adsr_pkg::PosW'(attack_end_i);
  assign d_end = adsr_pkg::PosW'(decay_end_i);

  always_comb begin
    t0   = d_end;
    t1   = release_end_i;
    lv0  = sustain_i;
    lv1  = '0;
    hold = 1'b0;
    if (!opcode_i) begin
      if (position_i < a_end) begin
        t0  = '0;
        t1  = a_end;
        lv0 = '0;
        lv1 = adsr_pkg::AMP_MAX;
      end else if (position_i <= d_end) begin
        t0  = a_end;
        t1  = d_end;
        lv0 = adsr_pkg::AMP_MAX;
        lv1 = sustain_i;
      end else begin
        hold = 1'b1;
      end
    end
  end

  always_comb begin
    seg_d.lv0  = lv0;
    seg_d.down = lv1 < lv0;
    seg_d.diff = (lv1 < lv0) ? (lv0 - lv1) : (lv1 - lv0);
    seg_d.off  = position_i - t0;
    seg_d.span = t1 - t0;
    // clamped cases become a zero-step ramp at the clamp level
    if (hold || position_i >= t1 || position_i < t0) begin
      seg_d.lv0  = (hold || position_i < t0) ? lv0 : lv1;
      seg_d.down = 1'b0;
      seg_d.diff = '0;
      seg_d.off  = '0;
      seg_d.span = adsr_pkg::PosW'(1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule

>>> rtl/adsr_mul.sv
// multiply stage: level delta times offset, divisor aligned for the divider
// depends on adsr_pkg
`timescale 1ns / 1ps

module adsr_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  adsr_pkg::seg_t seg_i,
  output logic           valid_o,
  input  logic           ready_i,
  output adsr_pkg::div_t div_o
);

  logic           valid_q;
  adsr_pkg::div_t div_d, div_q;

  always_comb begin
    div_d.lv0  = seg_i.lv0;
    div_d.down = seg_i.down;
    div_d.rem  = adsr_pkg::ProdW'(seg_i.diff) * adsr_pkg::ProdW'(seg_i.off);
    div_d.dsor = {seg_i.span, {(adsr_pkg::QuoW - 1){1'b0}}};
    div_d.quo  = '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

>>> rtl/adsr_div_step.sv
// one registered step of the restoring divider, one quotient bit
// depends on adsr_pkg
`timescale 1ns / 1ps

module adsr_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  adsr_pkg::div_t div_i,
  output logic           valid_o,
  input  logic           ready_i,
  output adsr_pkg::div_t div_o
);

  logic                       ge;
  logic [adsr_pkg::ProdW-1:0] dsor_ext;
  logic                       valid_q;
  adsr_pkg::div_t             div_d, div_q;

  assign dsor_ext = adsr_pkg::ProdW'(div_i.dsor);
  assign ge       = div_i.rem >= dsor_ext;

  always_comb begin
    div_d      = div_i;
    div_d.rem  = ge ? (div_i.rem - dsor_ext) : div_i.rem;
    div_d.dsor = div_i.dsor >> 1;
    div_d.quo  = {div_i.quo[adsr_pkg::QuoW-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

>>> rtl/linear_adsr_envelope_level.sv
// linear adsr envelope level: one amplitude per (opcode, position) query
// output valid after 15 register stages from the input transfer; one item per cycle
// throughput while out_ready_i is high, set by a fully pipelined 12-step restoring
// divider; input is held off in the cycle after a config transfer while end times settle
// every stage has its own valid bit and a skid-free local ready, so bubbles collapse
// async active-low reset clears all valid bits and config registers to zero
`timescale 1ns / 1ps

module linear_adsr_envelope_level (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // query channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       opcode_i,
  input  logic [adsr_pkg::PosW-1:0]  position_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [adsr_pkg::AmpW-1:0]  amplitude_o,
  // config write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [adsr_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [adsr_pkg::DataW-1:0] cfg_data_i
);

  // config registers
  logic [adsr_pkg::TimeW-1:0] attack_q, decay_q, release_q;
  logic [adsr_pkg::AmpW-1:0]  sustain_q;
  // cumulative end times, registered from the config registers; input transfers
  // are held off in the cycle after a config write so queries always see settled values
  logic [adsr_pkg::DEndW-1:0] d_end_q, d_end_d;
  logic [adsr_pkg::PosW-1:0]  r_end_q, r_end_d;
  logic                       cfg_load;
  logic                       cfg_settle_q;
  logic                       seg_in_valid, seg_in_ready;

  // pipeline links
  logic           seg_valid, seg_ready;
  adsr_pkg::seg_t seg;
  logic           div_valid [adsr_pkg::DivSteps+1];
  logic           div_ready [adsr_pkg::DivSteps+1];
  adsr_pkg::div_t div       [adsr_pkg::DivSteps+1];

  // output register
  logic                      out_valid_q;
  logic [adsr_pkg::AmpW-1:0] amp_q, amp_d;
  logic                      out_load;
  adsr_pkg::div_t            fin;

  // config port: always ready, writes beyond the register list are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_load    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      sustain_q <= '0;
      release_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        adsr_pkg::REG_ATTACK:  attack_q  <= cfg_data_i;
        adsr_pkg::REG_DECAY:   decay_q   <= cfg_data_i;
        adsr_pkg::REG_SUSTAIN: sustain_q <= cfg_data_i[adsr_pkg::AmpW-1:0];
        adsr_pkg::REG_RELEASE: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // end times never overflow: three 24-bit terms fit in 26 bits
  assign d_end_d = adsr_pkg::DEndW'(attack_q) + adsr_pkg::DEndW'(decay_q);
  assign r_end_d = adsr_pkg::PosW'(attack_q) + adsr_pkg::PosW'(decay_q)
                 + adsr_pkg::PosW'(release_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_end_q      <= '0;
      r_end_q      <= '0;
      cfg_settle_q <= 1'b0;
    end else begin
      d_end_q      <= d_end_d;
      r_end_q      <= r_end_d;
      cfg_settle_q <= cfg_load;
    end
  end

  // no query enters in the cycle where the end times still trail the registers
  assign seg_in_valid = in_valid_i && !cfg_settle_q;
  assign in_ready_o   = seg_in_ready && !cfg_settle_q;

  // stage 1: segment select and clamping
  adsr_seg u_seg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (seg_in_valid),
    .ready_o       (seg_in_ready),
    .opcode_i      (opcode_i),
    .position_i    (position_i),
    .attack_end_i  (attack_q),
    .decay_end_i   (d_end_q),
    .release_end_i (r_end_q),
    .sustain_i     (sustain_q),
    .valid_o       (seg_valid),
    .ready_i       (seg_ready),
    .seg_o         (seg)
  );

  // stage 2: delta times offset
  adsr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_valid),
    .ready_o (seg_ready),
    .seg_i   (seg),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .div_o   (div[0])
  );

  // stages 3..14: one quotient bit per stage, msb first
  for (genvar g = 0; g < adsr_pkg::DivSteps; g++) begin : g_div
    adsr_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .ready_o (div_ready[g]),
      .div_i   (div[g]),
      .valid_o (div_valid[g+1]),
      .ready_i (div_ready[g+1]),
      .div_o   (div[g+1])
    );
  end

  // stage 15: apply the truncated step to the start level
  assign fin      = div[adsr_pkg::DivSteps];
  assign amp_d    = fin.down ? (fin.lv0 - fin.quo) : (fin.lv0 + fin.quo);
  assign div_ready[adsr_pkg::DivSteps] = !out_valid_q || out_ready_i;
  assign out_load = div_valid[adsr_pkg::DivSteps] && div_ready[adsr_pkg::DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready[adsr_pkg::DivSteps]) begin
      out_valid_q <= div_valid[adsr_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      amp_q <= amp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign amplitude_o = amp_q;

  // a live ramp always has offset strictly inside its span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid |-> (seg.diff == '0) || (seg.off < seg.span))
    else $error("ramp offset outside its span");

  // a falling ramp never steps below zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[adsr_pkg::DivSteps] && fin.down) |-> (fin.quo <= fin.lv0))
    else $error("falling ramp step exceeds start level");

  // a rising ramp never passes full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[adsr_pkg::DivSteps] && !fin.down) |->
      ({1'b0, fin.lv0} + {1'b0, fin.quo} <= {1'b0, adsr_pkg::AMP_MAX}))
    else $error("rising ramp passes full scale");

  // product entering the divider stays below the span times 2^QuoW, so the quotient fits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid[0] |-> (div[0].rem < {div[0].dsor, 1'b0}))
    else $error("product too large for quotient width");

endmodule
